// ===== design/ghi_pkg.sv =====
// Shared types, constants and helpers of the gyro heading integrator.
// Used by every module of the block; depends on nothing.
package ghi_pkg;

  localparam int RawW   = 16;
  localparam int DtW    = 20;
  localparam int RateW  = 18;
  localparam int HeadW  = 17;
  localparam int SecW   = 4;
  localparam int ScaleW = 18;
  localparam int GainW  = 17;
  localparam int DzW    = 16;
  localparam int AccW   = 37;
  localparam int TotW   = 39;
  localparam int CfgIdxW  = 2;
  localparam int CfgDataW = 18;
  localparam int WideW  = 23;

  localparam logic [AccW-1:0]  FullTurnAcc = 37'd92160000000;
  localparam logic [DtW-1:0]   UsPerS      = 20'd1000000;
  localparam logic [HeadW-1:0] HalfSector  = 17'd5760;
  localparam logic [HeadW-1:0] SectorSpan  = 17'd11520;
  localparam logic [GainW-1:0] GainOne     = 17'd65536;
  localparam logic signed [RateW-1:0] RateMax = 18'sh1ffff;
  localparam logic signed [RateW-1:0] RateMin = 18'sh20000;

  localparam logic [ScaleW-1:0] ScaleRst = 18'd159908;
  localparam logic [GainW-1:0]  GainRst  = 17'd6554;
  localparam logic [DzW-1:0]    DzRst    = 16'd256;

  typedef enum logic [CfgIdxW-1:0] {
    RegRateScale  = 2'd0,
    RegFilterGain = 2'd1,
    RegDeadZone   = 2'd2
  } ghi_reg_e;

  typedef struct packed {
    logic [ScaleW-1:0] rate_scale;
    logic [GainW-1:0]  filter_gain;
    logic [DzW-1:0]    dead_zone;
  } ghi_cfg_t;

  typedef struct packed {
    logic signed [RateW-1:0] sample;
    logic [DtW-1:0]          dt;
  } ghi_item_t;

  typedef struct packed {
    logic [SecW-1:0]         sector;
    logic [HeadW-1:0]        heading;
    logic signed [RateW-1:0] filtered_rate;
  } ghi_result_t;

  function automatic logic signed [RateW-1:0] clamp_rate(input logic signed [WideW-1:0] v);
    logic signed [RateW-1:0] r;
    if (v > WideW'(RateMax)) begin
      r = RateMax;
    end else if (v < WideW'(RateMin)) begin
      r = RateMin;
    end else begin
      r = v[RateW-1:0];
    end
    return r;
  endfunction

endpackage

// ===== design/gyro_heading_integrator.sv =====
// The integrator takes a new transaction only after it has finished the last one,
// stepping through its filter, integration, wrap, division and output states;
// the heading uses one reciprocal multiply.
// Reset is asynchronous and active low; it loads the register defaults and
// clears the filtered rate, the heading accumulator and all queues.
module gyro_heading_integrator import ghi_pkg::*; #(
  parameter int FifoDepth = 2
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  // [15:0] raw_rate, [35:16] elapsed_us, [39:36] zero
  input  logic [39:0]         s_axis_tdata,
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  // [17:0] filtered_rate, [34:18] heading, [38:35] sector, [39] zero
  output logic [39:0]         m_axis_tdata
);

  ghi_cfg_t    cfg_q;
  logic        push;
  logic        full;
  ghi_item_t   push_item;
  logic        pop;
  logic        q_valid;
  ghi_item_t   q_item;
  ghi_result_t result;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.rate_scale  <= ScaleRst;
      cfg_q.filter_gain <= GainRst;
      cfg_q.dead_zone   <= DzRst;
    end else if (cfg_we_i) begin
      case (ghi_reg_e'(cfg_idx_i))
        RegRateScale:  cfg_q.rate_scale  <= cfg_data_i[ScaleW-1:0];
        RegFilterGain: cfg_q.filter_gain <= cfg_data_i[GainW-1:0];
        RegDeadZone:   cfg_q.dead_zone   <= cfg_data_i[DzW-1:0];
        default: ;
      endcase
    end
  end

  ghi_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .rate_scale_i (cfg_q.rate_scale),
    .in_valid_i   (s_axis_tvalid),
    .in_ready_o   (s_axis_tready),
    .raw_rate_i   ($signed(s_axis_tdata[RawW-1:0])),
    .elapsed_us_i (s_axis_tdata[RawW+DtW-1:RawW]),
    .full_i       (full),
    .push_o       (push),
    .item_o       (push_item)
  );

  ghi_fifo #(
    .Depth (FifoDepth)
  ) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .item_i  (push_item),
    .full_o  (full),
    .pop_i   (pop),
    .valid_o (q_valid),
    .item_o  (q_item)
  );

  ghi_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg_q),
    .item_valid_i (q_valid),
    .item_i       (q_item),
    .pop_o        (pop),
    .out_valid_o  (m_axis_tvalid),
    .out_ready_i  (m_axis_tready),
    .out_o        (result)
  );

  assign m_axis_tdata = {1'b0, result};

endmodule

// ===== design/ghi_front.sv =====
// Input side: takes gyro transactions, saturates the elapsed time and scales
// the raw sample to a rate in 1/256 dps. Depends on ghi_pkg.
module ghi_front import ghi_pkg::*; (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic [ScaleW-1:0]        rate_scale_i,
  input  logic                     in_valid_i,
  output logic                     in_ready_o,
  input  logic signed [RawW-1:0]   raw_rate_i,
  input  logic [DtW-1:0]           elapsed_us_i,
  input  logic                     full_i,
  output logic                     push_o,
  output ghi_item_t                item_o
);

  localparam int ProdW = RawW + ScaleW + 1;

  logic                     valid_q;
  logic signed [ProdW-1:0]  prod_q;
  logic signed [ProdW-1:0]  prod_d;
  logic [DtW-1:0]           dt_q;
  logic [DtW-1:0]           dt_d;
  logic signed [ProdW-1:0]  rounded;
  logic signed [ProdW-17:0] scaled;
  logic                     accept;

  assign push_o     = valid_q && !full_i;
  assign in_ready_o = !valid_q || !full_i;
  assign accept     = in_valid_i && in_ready_o;

  assign prod_d = raw_rate_i * $signed({1'b0, rate_scale_i});
  assign dt_d   = (elapsed_us_i > UsPerS) ? UsPerS : elapsed_us_i;

  assign rounded = prod_q + ProdW'(32768);
  assign scaled  = rounded[ProdW-1:16];

  assign item_o.sample = clamp_rate(WideW'(scaled));
  assign item_o.dt     = dt_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (accept) begin
      valid_q <= 1'b1;
    end else if (push_o) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      prod_q <= prod_d;
      dt_q   <= dt_d;
    end
  end

endmodule

// ===== design/ghi_fifo.sv =====
// Short queue of scaled samples between the input side and the integrator.
// Depends on ghi_pkg.
module ghi_fifo import ghi_pkg::*; #(
  parameter int Depth = 2
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      push_i,
  input  ghi_item_t item_i,
  output logic      full_o,
  input  logic      pop_i,
  output logic      valid_o,
  output ghi_item_t item_o
);

  localparam int AW = $clog2(Depth);

  ghi_item_t      mem_q [Depth];
  logic [AW-1:0]  wptr_q;
  logic [AW-1:0]  rptr_q;
  logic [AW:0]    cnt_q;
  logic           do_push;
  logic           do_pop;

  assign full_o  = (cnt_q == (AW+1)'(Depth));
  assign valid_o = (cnt_q != '0);
  assign item_o  = mem_q[rptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      if (do_push) begin
        wptr_q <= (wptr_q == AW'(Depth - 1)) ? '0 : wptr_q + AW'(1);
      end
      if (do_pop) begin
        rptr_q <= (rptr_q == AW'(Depth - 1)) ? '0 : rptr_q + AW'(1);
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + (AW+1)'(1);
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - (AW+1)'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wptr_q] <= item_i;
    end
  end

`ifndef SYNTH
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= (AW+1)'(Depth))
    else $error("queue count beyond depth");
`endif

endmodule

// ===== design/ghi_back.sv =====
// Integrator: low-pass filter, dead zone, heading accumulation with modulo
// wrap, reciprocal-multiply heading extraction and compass sector. Depends on ghi_pkg.
module ghi_back import ghi_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  ghi_cfg_t    cfg_i,
  input  logic        item_valid_i,
  input  ghi_item_t   item_i,
  output logic        pop_o,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output ghi_result_t out_o
);

  localparam int DiffW  = RateW + 1;
  localparam int GProdW = DiffW + GainW + 1;
  localparam int IncW   = GProdW - 16;
  localparam int SumW   = IncW + 1;
  localparam int AccSh  = 6;
  localparam int XW     = AccW - AccSh;
  localparam int HProdW = 2 * XW;
  localparam int RecipSh = 44;
  localparam logic [XW-1:0] Recip = 31'd1125899907;
  localparam logic [HeadW-1:0] HeadLimit = HeadW'(FullTurnAcc / AccW'(UsPerS));

  typedef enum logic [7:0] {
    StIdle = 8'b0000_0001,
    StMulG = 8'b0000_0010,
    StUpd  = 8'b0000_0100,
    StMulT = 8'b0000_1000,
    StAdd  = 8'b0001_0000,
    StWrap = 8'b0010_0000,
    StDiv  = 8'b0100_0000,
    StOut  = 8'b1000_0000
  } ghi_state_e;

  ghi_state_e               state_q;
  ghi_state_e               state_d;
  logic signed [RateW-1:0]  sample_q;
  logic [DtW-1:0]           dt_q;
  logic signed [RateW-1:0]  rate_q;
  logic signed [GProdW-1:0] gprod_q;
  logic signed [GProdW-1:0] gprod_d;
  logic signed [TotW-1:0]   tprod_q;
  logic signed [TotW-1:0]   tprod_d;
  logic signed [TotW-1:0]   tot_q;
  logic signed [TotW-1:0]   tot_d;
  logic [AccW-1:0]          acc_q;
  logic [HProdW-1:0]        hprod_q;
  logic [HProdW-1:0]        hprod_d;
  logic [HeadW-1:0]         quot;
  logic                     out_valid_q;
  ghi_result_t              out_q;

  logic [GainW-1:0]         gain_c;
  logic signed [DiffW-1:0]  diff;
  logic signed [GProdW-1:0] grounded;
  logic signed [IncW-1:0]   inc;
  logic signed [SumW-1:0]   rate_sum;
  logic signed [RateW-1:0]  rate_new;
  logic [RateW-1:0]         mag_new;
  logic signed [RateW-1:0]  rate_dz;
  logic [RateW-1:0]         rate_mag;
  logic [HeadW-1:0]         sec_x;
  logic [SecW-1:0]          sec_k;
  logic [SecW-1:0]          sector;
  logic                     load_out;
  logic                     tot_neg;
  logic                     tot_over;

  assign gain_c   = (cfg_i.filter_gain > GainOne) ? GainOne : cfg_i.filter_gain;
  assign diff     = DiffW'(sample_q) - DiffW'(rate_q);
  assign gprod_d  = diff * $signed({1'b0, gain_c});
  assign grounded = gprod_q + GProdW'(32768);
  assign inc      = grounded[GProdW-1:16];
  assign rate_sum = SumW'(rate_q) + SumW'(inc);
  assign rate_new = clamp_rate(WideW'(rate_sum));
  assign mag_new  = rate_new[RateW-1] ? RateW'(-rate_new) : RateW'(rate_new);
  assign rate_dz  = (mag_new < RateW'(cfg_i.dead_zone)) ? '0 : rate_new;
  assign rate_mag = rate_q[RateW-1] ? RateW'(-rate_q) : RateW'(rate_q);

  assign tprod_d  = rate_q * $signed({1'b0, dt_q});
  assign tot_d    = $signed({2'b00, acc_q}) + tprod_q;
  assign tot_neg  = tot_q[TotW-1];
  assign tot_over = (tot_q >= $signed({2'b00, FullTurnAcc}));

  // The accumulator divided by 64 stays below 2^31, so one reciprocal of
  // 15625 scaled by 2^44 gives the exact floor of the division by one million.
  assign hprod_d = HProdW'(acc_q[AccW-1:AccSh]) * HProdW'(Recip);
  assign quot    = hprod_q[RecipSh+HeadW-1:RecipSh];

  assign sec_x = quot + HalfSector;

  always_comb begin
    sec_k = '0;
    for (int j = 1; j <= 8; j++) begin
      if (sec_x >= HeadW'(j) * SectorSpan) begin
        sec_k = sec_k + SecW'(1);
      end
    end
    sector = {1'b0, sec_k[2:0]} + SecW'(1);
  end

  assign pop_o    = (state_q == StIdle) && item_valid_i;
  assign load_out = (state_q == StOut) && (!out_valid_q || out_ready_i);

  always_comb begin
    state_d = state_q;
    case (state_q)
      StIdle: if (item_valid_i) state_d = StMulG;
      StMulG: state_d = StUpd;
      StUpd:  state_d = StMulT;
      StMulT: state_d = StAdd;
      StAdd:  state_d = StWrap;
      StWrap: if (!tot_neg && !tot_over) state_d = StDiv;
      StDiv:  state_d = StOut;
      StOut:  if (load_out) state_d = StIdle;
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      rate_q      <= '0;
      acc_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == StUpd) begin
        rate_q <= rate_dz;
      end
      if ((state_q == StWrap) && !tot_neg && !tot_over) begin
        acc_q <= tot_q[AccW-1:0];
      end
      if (load_out) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      sample_q <= item_i.sample;
      dt_q     <= item_i.dt;
    end
    if (state_q == StMulG) begin
      gprod_q <= gprod_d;
    end
    if (state_q == StMulT) begin
      tprod_q <= tprod_d;
    end
    if (state_q == StAdd) begin
      tot_q <= tot_d;
    end
    if (state_q == StWrap) begin
      if (tot_neg) begin
        tot_q <= tot_q + $signed({2'b00, FullTurnAcc});
      end else if (tot_over) begin
        tot_q <= tot_q - $signed({2'b00, FullTurnAcc});
      end
    end
    if (state_q == StDiv) begin
      hprod_q <= hprod_d;
    end
    if (load_out) begin
      out_q.sector        <= sector;
      out_q.heading       <= quot;
      out_q.filtered_rate <= rate_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;

`ifndef SYNTH
  a_acc_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    acc_q < FullTurnAcc)
    else $error("heading accumulator outside one turn");

  a_head_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == StOut |-> quot < HeadLimit)
    else $error("heading outside one turn");

  a_dead_zone: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == StUpd |=> (rate_q == '0 || rate_mag >= RateW'(cfg_i.dead_zone)))
    else $error("stored rate inside dead zone");

  a_out_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load_out |=> out_valid_q && out_q.heading == $past(quot))
    else $error("result register not loaded");
`endif

endmodule
